// ===== design/pbb_pkg.sv =====
// ----------------------------------------------------------------------------
// pbb_pkg: shared definitions for phased block binning
// Field widths, register indexes, parameter defaults and the tag that travels
// with each sample through the pipeline.
// ----------------------------------------------------------------------------
package pbb_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int BINS_W      = 5;
  localparam int PHASE_W     = 7;
  localparam int BIN_ROW_W   = 5;
  localparam int BIN_COL_W   = 5;
  localparam int BLOCK_SUM_W = 39;
  localparam int CFG_IDX_W   = 2;

  localparam int BIN_DEF      = 10;
  localparam int MAX_COLS_DEF = 256;

  localparam logic [BINS_W-1:0] BINS_RESET = BINS_W'(24);

  localparam logic [CFG_IDX_W-1:0] CFG_BINS_DOWN   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BINS_ACROSS = CFG_IDX_W'(1);

  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic [BIN_ROW_W-1:0] bin_row;
    logic [BIN_COL_W-1:0] bin_col;
    logic                 emit;
    logic                 last;
    logic                 row_start;
    logic                 row_warm;
    logic                 col_start;
    logic                 col_warm;
  } tag_t;

endpackage

// ===== design/phased_block_binning_10x10.sv =====
// ----------------------------------------------------------------------------
// phased_block_binning_10x10: phased BINxBIN block binning of a raster image
// Sums every BINxBIN window whose top left lies at row 1 and column 1 or
// later, which covers every phase of the binned image, and tags each sum with
// its phase index, bin row and bin column.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_sample
//   out      output     out_valid / out_stall out_phase, out_bin_row,
//                                             out_bin_col, out_block_sum,
//                                             out_last
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One sample is accepted per cycle while in_stall is low; the rate is set by
// the read-modify-write of the column-sum memory, which takes one read and one
// write each cycle. Reset needs no clearing pass: the first BIN rows of each
// image ignore the line store and the first row ignores the column sums. A
// stalled result backs up the pipeline stage by stage and holds in_stall
// high once all stages are full.
// ----------------------------------------------------------------------------
module phased_block_binning_10x10 #(
  parameter int BIN      = pbb_pkg::BIN_DEF,
  parameter int MAX_COLS = pbb_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [pbb_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [pbb_pkg::PHASE_W-1:0]            out_phase,
  output logic [pbb_pkg::BIN_ROW_W-1:0]          out_bin_row,
  output logic [pbb_pkg::BIN_COL_W-1:0]          out_bin_col,
  output logic signed [pbb_pkg::BLOCK_SUM_W-1:0] out_block_sum,
  output logic                                   out_last,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pbb_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [pbb_pkg::BINS_W-1:0]             cfg_data
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int RS_AW = $clog2(BIN*MAX_COLS);
  localparam int CS_W  = pbb_pkg::SAMPLE_W + $clog2(BIN);

  pbb_pkg::tag_t          scan_tag;
  pbb_pkg::tag_t          s1_tag;
  logic [COL_W-1:0]       scan_col;
  logic [RS_AW-1:0]       scan_rs_addr;
  logic                   in_fire;
  logic                   s1_valid;
  logic                   s1_ready;
  logic                   s2_ready;
  logic signed [CS_W-1:0] s1_cs;

  assign cfg_ready = 1'b1;
  assign in_stall  = !s1_ready;
  assign in_fire   = in_valid && s1_ready;

  pbb_scan #(.BIN(BIN), .MAX_COLS(MAX_COLS)) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tag       (scan_tag),
    .col       (scan_col),
    .rs_addr   (scan_rs_addr)
  );

  pbb_colsum #(.BIN(BIN), .MAX_COLS(MAX_COLS)) u_colsum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_sample  (in_sample),
    .tag_in     (scan_tag),
    .col_in     (scan_col),
    .rs_addr_in (scan_rs_addr),
    .s2_ready   (s2_ready),
    .s1_valid   (s1_valid),
    .s1_ready   (s1_ready),
    .cs_out     (s1_cs),
    .tag_out    (s1_tag)
  );

  pbb_window #(.BIN(BIN)) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .s1_valid      (s1_valid),
    .cs_in         (s1_cs),
    .tag_in        (s1_tag),
    .s2_ready      (s2_ready),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_phase     (out_phase),
    .out_bin_row   (out_bin_row),
    .out_bin_col   (out_bin_col),
    .out_block_sum (out_block_sum),
    .out_last      (out_last)
  );

endmodule

// ===== design/pbb_ram.sv =====
// ----------------------------------------------------------------------------
// pbb_ram: generic single-write, single-read memory
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module pbb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pbb_scan.sv =====
// ----------------------------------------------------------------------------
// pbb_scan: configuration registers and raster position
// Holds the bin counts, tracks the pixel position as phase and bin counters,
// and forms the memory addresses and the tag of the next sample.
// ----------------------------------------------------------------------------
module pbb_scan #(
  parameter int BIN      = pbb_pkg::BIN_DEF,
  parameter int MAX_COLS = pbb_pkg::MAX_COLS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_fire,
  input  logic                                  cfg_valid,
  input  logic [pbb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pbb_pkg::BINS_W-1:0]            cfg_data,
  output pbb_pkg::tag_t                         tag,
  output logic [$clog2(MAX_COLS)-1:0]           col,
  output logic [$clog2(BIN*MAX_COLS)-1:0]       rs_addr
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int RS_AW = $clog2(BIN*MAX_COLS);
  localparam int PH_W  = $clog2(BIN);
  localparam int LIM   = (MAX_COLS - BIN) / BIN;
  localparam int CB_W  = $clog2(LIM + 1);
  localparam int RB_W  = pbb_pkg::BINS_W;

  logic [pbb_pkg::BINS_W-1:0] bins_down_r, bins_down_nxt;
  logic [pbb_pkg::BINS_W-1:0] bins_across_r, bins_across_nxt;
  logic [COL_W-1:0]           c_r, c_nxt;
  logic [PH_W-1:0]            cph_r, cph_nxt;
  logic [CB_W-1:0]            cbin_r, cbin_nxt;
  logic [PH_W-1:0]            rph_r, rph_nxt;
  logic [RB_W-1:0]            rbin_r, rbin_nxt;
  logic [RB_W-1:0]            bd_eff;
  logic [CB_W-1:0]            ba_eff;
  logic                       cfg_hit;
  logic                       col_end;
  logic                       row_end;

  assign bd_eff = (bins_down_r == '0) ? RB_W'(1) : bins_down_r;

  always_comb begin
    if (int'(bins_across_r) > LIM) begin
      ba_eff = CB_W'(LIM);
    end else if (bins_across_r == '0) begin
      ba_eff = CB_W'(1);
    end else begin
      ba_eff = CB_W'(bins_across_r);
    end
  end

  assign col_end = (cbin_r == ba_eff) && (cph_r == PH_W'(BIN - 1));
  assign row_end = (rbin_r == bd_eff) && (rph_r == PH_W'(BIN - 1));

  always_comb begin
    cfg_hit         = 1'b0;
    bins_down_nxt   = bins_down_r;
    bins_across_nxt = bins_across_r;
    if (cfg_valid) begin
      case (cfg_index)
        pbb_pkg::CFG_BINS_DOWN: begin
          bins_down_nxt = cfg_data;
          cfg_hit       = 1'b1;
        end
        pbb_pkg::CFG_BINS_ACROSS: begin
          bins_across_nxt = cfg_data;
          cfg_hit         = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    c_nxt    = c_r;
    cph_nxt  = cph_r;
    cbin_nxt = cbin_r;
    rph_nxt  = rph_r;
    rbin_nxt = rbin_r;
    if (cfg_hit) begin
      c_nxt    = '0;
      cph_nxt  = '0;
      cbin_nxt = '0;
      rph_nxt  = '0;
      rbin_nxt = '0;
    end else if (in_fire) begin
      if (col_end) begin
        c_nxt    = '0;
        cph_nxt  = '0;
        cbin_nxt = '0;
        if (row_end) begin
          rph_nxt  = '0;
          rbin_nxt = '0;
        end else if (rph_r == PH_W'(BIN - 1)) begin
          rph_nxt  = '0;
          rbin_nxt = rbin_r + RB_W'(1);
        end else begin
          rph_nxt = rph_r + PH_W'(1);
        end
      end else begin
        c_nxt = c_r + COL_W'(1);
        if (cph_r == PH_W'(BIN - 1)) begin
          cph_nxt  = '0;
          cbin_nxt = cbin_r + CB_W'(1);
        end else begin
          cph_nxt = cph_r + PH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_down_r   <= pbb_pkg::BINS_RESET;
      bins_across_r <= pbb_pkg::BINS_RESET;
      c_r           <= '0;
      cph_r         <= '0;
      cbin_r        <= '0;
      rph_r         <= '0;
      rbin_r        <= '0;
    end else begin
      bins_down_r   <= bins_down_nxt;
      bins_across_r <= bins_across_nxt;
      c_r           <= c_nxt;
      cph_r         <= cph_nxt;
      cbin_r        <= cbin_nxt;
      rph_r         <= rph_nxt;
      rbin_r        <= rbin_nxt;
    end
  end

  always_comb begin
    tag.phase     = pbb_pkg::PHASE_W'(int'(cph_r) * BIN + int'(rph_r));
    tag.bin_row   = pbb_pkg::BIN_ROW_W'(int'(rbin_r) - 1);
    tag.bin_col   = pbb_pkg::BIN_COL_W'(int'(cbin_r) - 1);
    tag.emit      = (rbin_r != '0) && (cbin_r != '0);
    tag.last      = col_end && row_end;
    tag.row_start = (rbin_r == '0) && (rph_r == '0);
    tag.row_warm  = (rbin_r != '0);
    tag.col_start = (c_r == '0);
    tag.col_warm  = (cbin_r != '0);
  end

  assign col     = c_r;
  assign rs_addr = RS_AW'(int'(rph_r) * MAX_COLS + int'(c_r));

  a_wrap_to_origin: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !cfg_valid && col_end && row_end |=>
      (c_r == '0) && (rbin_r == '0) && (rph_r == '0) && (cbin_r == '0))
    else $error("position did not return to the origin after the final pixel");

  a_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (c_r == '0) == ((cbin_r == '0) && (cph_r == '0)))
    else $error("column counter and its phase and bin counters disagree");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cph_r) < BIN) && (int'(rph_r) < BIN))
    else $error("phase counter out of range");

endmodule

// ===== design/pbb_colsum.sv =====
// ----------------------------------------------------------------------------
// pbb_colsum: line store and column sums
// Registers the accepted sample, reads the sample of the same column BIN rows
// back and the running column sum, and writes both updated values back.
// ----------------------------------------------------------------------------
module pbb_colsum #(
  parameter int BIN      = pbb_pkg::BIN_DEF,
  parameter int MAX_COLS = pbb_pkg::MAX_COLS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           in_fire,
  input  logic signed [pbb_pkg::SAMPLE_W-1:0]            in_sample,
  input  pbb_pkg::tag_t                                  tag_in,
  input  logic [$clog2(MAX_COLS)-1:0]                    col_in,
  input  logic [$clog2(BIN*MAX_COLS)-1:0]                rs_addr_in,
  input  logic                                           s2_ready,
  output logic                                           s1_valid,
  output logic                                           s1_ready,
  output logic signed [pbb_pkg::SAMPLE_W+$clog2(BIN)-1:0] cs_out,
  output pbb_pkg::tag_t                                  tag_out
);

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int RS_AW = $clog2(BIN*MAX_COLS);
  localparam int SW    = pbb_pkg::SAMPLE_W;
  localparam int CS_W  = SW + $clog2(BIN);

  logic                    s1_valid_r, s1_valid_nxt;
  logic signed [SW-1:0]    x_r;
  pbb_pkg::tag_t           tag_r;
  logic [COL_W-1:0]        c_r;
  logic [RS_AW-1:0]        rs_addr_r;
  logic                    s1_go;
  logic [SW-1:0]           rs_rd;
  logic [CS_W-1:0]         cs_rd;
  logic signed [CS_W-1:0]  cs_prev;
  logic signed [CS_W-1:0]  x_ext;
  logic signed [CS_W-1:0]  old_ext;
  logic signed [CS_W-1:0]  cs_new;

  pbb_ram #(.WIDTH(SW), .DEPTH(BIN*MAX_COLS)) u_row_store (
    .clk   (clk),
    .we    (s1_go),
    .waddr (rs_addr_r),
    .wdata (x_r),
    .re    (in_fire),
    .raddr (rs_addr_in),
    .rdata (rs_rd)
  );

  pbb_ram #(.WIDTH(CS_W), .DEPTH(MAX_COLS)) u_col_sums (
    .clk   (clk),
    .we    (s1_go),
    .waddr (c_r),
    .wdata (cs_new),
    .re    (in_fire),
    .raddr (col_in),
    .rdata (cs_rd)
  );

  assign s1_go    = s1_valid_r && s2_ready;
  assign s1_ready = !s1_valid_r || s2_ready;

  always_comb begin
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r       <= in_sample;
      tag_r     <= tag_in;
      c_r       <= col_in;
      rs_addr_r <= rs_addr_in;
    end
  end

  assign x_ext   = {{(CS_W-SW){x_r[SW-1]}}, x_r};
  assign old_ext = tag_r.row_warm ? {{(CS_W-SW){rs_rd[SW-1]}}, rs_rd} : '0;
  assign cs_prev = tag_r.row_start ? '0 : cs_rd;
  assign cs_new  = cs_prev + x_ext - old_ext;

  assign s1_valid = s1_valid_r;
  assign cs_out   = cs_new;
  assign tag_out  = tag_r;

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(c_r) && $stable(rs_addr_r))
    else $error("blocked column stage lost its sample");

endmodule

// ===== design/pbb_window.sv =====
// ----------------------------------------------------------------------------
// pbb_window: window sum and result register
// Keeps the last BIN column sums of the row and the running window total,
// and loads the result register for every complete window.
// ----------------------------------------------------------------------------
module pbb_window #(
  parameter int BIN = pbb_pkg::BIN_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            s1_valid,
  input  logic signed [pbb_pkg::SAMPLE_W+$clog2(BIN)-1:0] cs_in,
  input  pbb_pkg::tag_t                                   tag_in,
  output logic                                            s2_ready,
  input  logic                                            out_stall,
  output logic                                            out_valid,
  output logic [pbb_pkg::PHASE_W-1:0]                     out_phase,
  output logic [pbb_pkg::BIN_ROW_W-1:0]                   out_bin_row,
  output logic [pbb_pkg::BIN_COL_W-1:0]                   out_bin_col,
  output logic signed [pbb_pkg::BLOCK_SUM_W-1:0]          out_block_sum,
  output logic                                            out_last
);

  localparam int CS_W = pbb_pkg::SAMPLE_W + $clog2(BIN);
  localparam int WT_W = pbb_pkg::SAMPLE_W + $clog2(BIN*BIN);

  logic                          s2_valid_r, s2_valid_nxt;
  logic signed [CS_W-1:0]        cs_r;
  pbb_pkg::tag_t                 tag_r;
  logic signed [CS_W-1:0]        recent_r [BIN];
  logic signed [WT_W-1:0]        wt_r;
  logic signed [WT_W-1:0]        wt_nxt;
  logic signed [WT_W-1:0]        wt_base;
  logic signed [WT_W-1:0]        cs_ext;
  logic signed [WT_W-1:0]        oldest_ext;
  logic                          out_valid_r, out_valid_nxt;
  logic [pbb_pkg::PHASE_W-1:0]   phase_r;
  logic [pbb_pkg::BIN_ROW_W-1:0] bin_row_r;
  logic [pbb_pkg::BIN_COL_W-1:0] bin_col_r;
  logic signed [pbb_pkg::BLOCK_SUM_W-1:0] block_sum_r;
  logic                          last_r;
  logic                          out_free;
  logic                          s1_go;
  logic                          s2_go;
  logic                          load_out;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_go    = s2_valid_r && (!tag_r.emit || out_free);
  assign s2_ready = !s2_valid_r || s2_go;
  assign s1_go    = s1_valid && s2_ready;
  assign load_out = s2_go && tag_r.emit;

  assign cs_ext     = {{(WT_W-CS_W){cs_r[CS_W-1]}}, cs_r};
  assign oldest_ext = tag_r.col_warm ?
                      {{(WT_W-CS_W){recent_r[BIN-1][CS_W-1]}}, recent_r[BIN-1]} : '0;
  assign wt_base    = tag_r.col_start ? '0 : wt_r;
  assign wt_nxt     = wt_base + cs_ext - oldest_ext;

  always_comb begin
    if (s1_go) begin
      s2_valid_nxt = 1'b1;
    end else if (s2_go) begin
      s2_valid_nxt = 1'b0;
    end else begin
      s2_valid_nxt = s2_valid_r;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      cs_r  <= cs_in;
      tag_r <= tag_in;
    end
    if (s2_go) begin
      wt_r        <= wt_nxt;
      recent_r[0] <= cs_r;
      for (int i = 1; i < BIN; i++) begin
        recent_r[i] <= recent_r[i-1];
      end
    end
    if (load_out) begin
      phase_r     <= tag_r.phase;
      bin_row_r   <= tag_r.bin_row;
      bin_col_r   <= tag_r.bin_col;
      block_sum_r <= pbb_pkg::BLOCK_SUM_W'(wt_nxt);
      last_r      <= tag_r.last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_phase     = phase_r;
  assign out_bin_row   = bin_row_r;
  assign out_bin_col   = bin_col_r;
  assign out_block_sum = block_sum_r;
  assign out_last      = last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !load_out)
    else $error("waiting result overwritten");

  a_last_is_window: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && tag_r.last |-> tag_r.emit && tag_r.row_warm && tag_r.col_warm)
    else $error("final pixel flagged on an incomplete window");

endmodule

// ===== bench/tb_phased_block_binning_10x10.sv =====
// ----------------------------------------------------------------------------
// tb_phased_block_binning_10x10: self-checking bench for phased block binning
// Streams raster images of several sizes into the block, tracks the column
// sums and window sums of every pixel in a scoreboard, and compares each
// window result field by field in arrival order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_phased_block_binning_10x10;

  localparam int BIN  = pbb_pkg::BIN_DEF;
  localparam int COLS = pbb_pkg::MAX_COLS_DEF;
  localparam logic [pbb_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = pbb_pkg::CFG_IDX_W'(2);
  localparam logic [pbb_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = pbb_pkg::CFG_IDX_W'(3);

  typedef enum {FILL_RANDOM, FILL_MAX, FILL_MIN} fill_t;

  typedef struct {
    logic [pbb_pkg::PHASE_W-1:0]            phase;
    logic [pbb_pkg::BIN_ROW_W-1:0]          bin_row;
    logic [pbb_pkg::BIN_COL_W-1:0]          bin_col;
    logic signed [pbb_pkg::BLOCK_SUM_W-1:0] block_sum;
    logic                                   last;
  } window_t;

  class window_sum_tracker;
    logic [pbb_pkg::BINS_W-1:0] bins_down;
    logic [pbb_pkg::BINS_W-1:0] bins_across;
    longint            line_mem[BIN*COLS];
    longint            col_acc[COLS];
    longint            recent_cols[BIN];
    longint            win_acc;
    int unsigned       row_pos;
    int unsigned       col_pos;
    window_t           windows_due[$];
    int                failures;
    int                windows_checked;

    function void power_on();
      bins_down = pbb_pkg::BINS_RESET;
      bins_across = pbb_pkg::BINS_RESET;
      failures = 0;
      windows_checked = 0;
      restart_image();
    endfunction

    function void restart_image();
      foreach (col_acc[i]) col_acc[i] = 0;
      foreach (recent_cols[i]) recent_cols[i] = 0;
      win_acc = 0;
      row_pos = 0;
      col_pos = 0;
    endfunction

    function int unsigned image_rows();
      int unsigned b;
      b = bins_down;
      if (b < 1) b = 1;
      return BIN * b + BIN;
    endfunction

    function int unsigned image_cols();
      int unsigned b;
      b = bins_across;
      if (b > (COLS - BIN) / BIN) b = (COLS - BIN) / BIN;
      if (b < 1) b = 1;
      return BIN * b + BIN;
    endfunction

    function void apply_register(logic [pbb_pkg::CFG_IDX_W-1:0] idx,
                                 logic [pbb_pkg::BINS_W-1:0] data);
      if (idx == pbb_pkg::CFG_BINS_DOWN) begin
        bins_down = data;
      end else if (idx == pbb_pkg::CFG_BINS_ACROSS) begin
        bins_across = data;
      end else begin
        return;
      end
      restart_image();
    endfunction

    function void take_pixel(logic signed [pbb_pkg::SAMPLE_W-1:0] sample);
      longint      x;
      int unsigned nr, nc, r, c, slot;
      window_t     w;
      x = sample;
      nr = image_rows();
      nc = image_cols();
      r = row_pos;
      c = col_pos;
      if (c >= nc || c >= COLS) c = 0;
      if (r >= nr) r = 0;
      slot = (r % BIN) * COLS + c;
      if (r >= BIN) col_acc[c] += x - line_mem[slot];
      else col_acc[c] += x;
      line_mem[slot] = x;
      if (c == 0) begin
        foreach (recent_cols[i]) recent_cols[i] = 0;
        win_acc = 0;
      end
      win_acc += col_acc[c] - recent_cols[c % BIN];
      recent_cols[c % BIN] = col_acc[c];
      if (r >= BIN && c >= BIN) begin
        w.phase = pbb_pkg::PHASE_W'(((c - BIN) % BIN) * BIN + (r - BIN) % BIN);
        w.bin_row = pbb_pkg::BIN_ROW_W'((r - BIN) / BIN);
        w.bin_col = pbb_pkg::BIN_COL_W'((c - BIN) / BIN);
        w.block_sum = win_acc[pbb_pkg::BLOCK_SUM_W-1:0];
        w.last = (r == nr - 1) && (c == nc - 1);
        windows_due.push_back(w);
      end
      c++;
      if (c >= nc) begin
        c = 0;
        r++;
        if (r >= nr) begin
          restart_image();
          return;
        end
      end
      row_pos = r;
      col_pos = c;
    endfunction

    function int pending();
      return windows_due.size();
    endfunction

    function void compare_window(window_t got);
      window_t want;
      windows_checked++;
      if (windows_due.size() == 0) begin
        $error("window result with no window outstanding: phase %0d row %0d col %0d",
               got.phase, got.bin_row, got.bin_col);
        failures++;
        return;
      end
      want = windows_due.pop_front();
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        failures++;
      end
      if (got.bin_row !== want.bin_row) begin
        $error("bin_row: expected %0d, got %0d", want.bin_row, got.bin_row);
        failures++;
      end
      if (got.bin_col !== want.bin_col) begin
        $error("bin_col: expected %0d, got %0d", want.bin_col, got.bin_col);
        failures++;
      end
      if (got.block_sum !== want.block_sum) begin
        $error("block_sum: expected %0d, got %0d", want.block_sum, got.block_sum);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        failures++;
      end
    endfunction
  endclass

  logic                                   clk = 1'b0;
  logic                                   rst_n = 1'b0;
  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic signed [pbb_pkg::SAMPLE_W-1:0]    in_sample = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic [pbb_pkg::PHASE_W-1:0]            out_phase;
  logic [pbb_pkg::BIN_ROW_W-1:0]          out_bin_row;
  logic [pbb_pkg::BIN_COL_W-1:0]          out_bin_col;
  logic signed [pbb_pkg::BLOCK_SUM_W-1:0] out_block_sum;
  logic                                   out_last;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [pbb_pkg::CFG_IDX_W-1:0]          cfg_index = '0;
  logic [pbb_pkg::BINS_W-1:0]             cfg_data = '0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int fed = 0;

  window_sum_tracker tracker;

  phased_block_binning_10x10 u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample    (in_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_phase    (out_phase),
    .out_bin_row  (out_bin_row),
    .out_bin_col  (out_bin_col),
    .out_block_sum(out_block_sum),
    .out_last     (out_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 14);
    end
  end

  always @(posedge clk) begin
    window_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.phase = out_phase;
      got.bin_row = out_bin_row;
      got.bin_col = out_bin_col;
      got.block_sum = out_block_sum;
      got.last = out_last;
      tracker.compare_window(got);
    end
  end

  function automatic logic signed [pbb_pkg::SAMPLE_W-1:0] pick_sample(fill_t mode);
    logic signed [pbb_pkg::SAMPLE_W-1:0] s;
    case (mode)
      FILL_MAX: s = 32'sh7fffffff;
      FILL_MIN: s = 32'sh80000000;
      default: begin
        case ($urandom_range(7))
          0: s = 32'sh7fffffff;
          1: s = 32'sh80000000;
          2: s = '0;
          3: s = -1;
          default: s = $urandom;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [pbb_pkg::BINS_W-1:0] pick_bins();
    if ($urandom_range(99) < 80) return pbb_pkg::BINS_W'($urandom_range(3));
    return pbb_pkg::BINS_W'($urandom_range(31));
  endfunction

  task automatic feed_pixels(input int count, input fill_t mode);
    logic signed [pbb_pkg::SAMPLE_W-1:0] s;
    for (int i = 0; i < count; i++) begin
      if (!calm && $urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      s = pick_sample(mode);
      in_valid <= 1'b1;
      in_sample <= s;
      do @(posedge clk); while (in_stall);
      tracker.take_pixel(s);
      fed++;
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pbb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pbb_pkg::BINS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.apply_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int stop_at;
    tracker = new;
    tracker.power_on();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Start of an image at the reset size.
    feed_pixels(30, FILL_RANDOM);
    settle();

    // Smallest image with a long output hold-off, then writes to unused
    // indexes in the middle of the image.
    calm <= 1'b1;
    hold_req <= 1'b1;
    write_reg(pbb_pkg::CFG_BINS_DOWN, pbb_pkg::BINS_W'(0));
    write_reg(pbb_pkg::CFG_BINS_ACROSS, pbb_pkg::BINS_W'(0));
    feed_pixels(220, FILL_MAX);
    settle();
    calm <= 1'b0;
    write_reg(CFG_SPARE_A, pbb_pkg::BINS_W'($urandom));
    write_reg(CFG_SPARE_B, pbb_pkg::BINS_W'($urandom));
    feed_pixels(100, FILL_MIN);
    feed_pixels(80, FILL_RANDOM);
    settle();

    stop_at = fed + 100;
    while (fed < stop_at) begin
      if ($urandom_range(99) < 60) begin
        settle();
        if ($urandom_range(3) == 0)
          write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, pick_bins());
        if ($urandom_range(1)) write_reg(pbb_pkg::CFG_BINS_DOWN, pick_bins());
        if ($urandom_range(1)) write_reg(pbb_pkg::CFG_BINS_ACROSS, pick_bins());
      end
      feed_pixels($urandom_range(20, 50), FILL_RANDOM);
    end
    settle();

    if (tracker.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
